FILE: hw/rtl/assert_macros.svh
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: hw/rtl/bsrt_pkg.sv
// types and constants of the bad sector remap table
`default_nettype none

package bsrt_pkg;

  // request kinds carried on the slave tuser
  typedef enum logic [1:0] {
    REQ_REMAP  = 2'd0,
    REQ_VERIFY = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_PING   = 2'd3
  } req_e;

  // result codes carried on the master tuser
  typedef enum logic [2:0] {
    ST_REMAPPED     = 3'd0,
    ST_ALREADY      = 3'd1,
    ST_NO_SPARE     = 3'd2,
    ST_FOUND        = 3'd3,
    ST_NOT_REMAPPED = 3'd4,
    ST_CLEARED      = 3'd5,
    ST_PONG         = 3'd6
  } status_e;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_COUNT = 8'd1;

  localparam int unsigned SPARE_COUNT_W = 7;
  localparam logic [SPARE_COUNT_W-1:0] SPARE_COUNT_RESET = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic accept;  // capture the incoming beat
    logic scan;    // walk the used entries
    logic finish;  // commit the result and update the table
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;       // compared entry matches
    logic scan_end;  // nothing left to compare
    logic out_free;  // output register can take a result
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bad_sector_remap_table.sv
// top level of the bad sector remap table
`default_nettype none

// Bad sector remap table. Each slave beat carries one request (tuser: remap,
// verify, clear or ping; tdata: sector number) and yields exactly one master
// beat (tuser: status code; tdata: spare sector, zero unless remapped or
// found). Remap and verify walk the used entries of a table with one write
// port and one registered read port, one entry per cycle; clear and ping
// skip the walk. The block works on one request at a time: tready drops after
// each accepted beat and returns once the result sits in the output register,
// so a new request may be taken while the previous result still waits for the
// downstream side. A remap appends the sector and assigns spare_base plus the
// slot index, wrapping at SECTOR_BITS bits; the assigned spare is stored with
// the entry, so a later change of spare_base does not alter what verify
// reports. The usable slot count is the smaller of spare_count and
// TABLE_DEPTH. Configuration writes are always taken (cfg_ready_o is tied
// high) and are meant to happen while no request is in flight. Table contents
// are not cleared at reset: only entries below the fill count are ever read.
module bad_sector_remap_table
  import bsrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned SECTOR_BITS = 48,
  localparam int unsigned DataW = ((SECTOR_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DataW-1:0]       s_axis_tdata,   // sector
  input  logic [1:0]             s_axis_tuser,   // req_type
  // result channel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [DataW-1:0]       m_axis_tdata,   // spare
  output logic [2:0]             m_axis_tuser,   // status
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SECTOR_BITS-1:0] cfg_data_i
);

  dp_cmd_t                cmd;
  dp_sts_t                sts;
  status_e                out_status;
  logic [SECTOR_BITS-1:0] out_spare;

  // sequencing: idle, scan, finish
  bsrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table storage, compare, config registers and output register
  bsrt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_req_i     (req_e'(s_axis_tuser)),
    .in_sector_i  (s_axis_tdata[SECTOR_BITS-1:0]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_spare_o  (out_spare)
  );

  // unused upper tdata bits are zero
  assign m_axis_tdata = DataW'(out_spare);
  assign m_axis_tuser = out_status;
  assign cfg_ready_o  = 1'b1;

endmodule

`default_nettype wire

FILE: hw/rtl/bsrt_ctrl.sv
// controller state machine of the bad sector remap table
`default_nettype none

module bsrt_ctrl
  import bsrt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.scan_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bsrt_dp.sv
// datapath: table memory, scan counter, config registers, result register
`default_nettype none

module bsrt_dp
  import bsrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned SECTOR_BITS = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  req_e                   in_req_i,
  input  logic [SECTOR_BITS-1:0] in_sector_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SECTOR_BITS-1:0] cfg_data_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output status_e                out_status_o,
  output logic [SECTOR_BITS-1:0] out_spare_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UsedW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CmpW  = (UsedW > SPARE_COUNT_W) ? UsedW : SPARE_COUNT_W;
  localparam int unsigned SB    = SECTOR_BITS;

  // each entry holds {spare, sector}
  logic [2*SB-1:0] mem_q [TABLE_DEPTH];
  logic [2*SB-1:0] rd_data_q;

  logic [SB-1:0]            spare_base_q;
  logic [SPARE_COUNT_W-1:0] spare_count_q;
  logic [UsedW-1:0]         used_q, used_d;
  logic [UsedW-1:0]         cnt_q, cnt_d;
  logic                     rd_vld_q, rd_vld_d;
  logic                     found_q, found_d;
  logic                     out_valid_q, out_valid_d;

  req_e          req_q;
  logic [SB-1:0] sec_q;
  logic [SB-1:0] found_spare_q;
  status_e       out_status_q;
  logic [SB-1:0] out_spare_q;

  logic          search;
  logic          more;
  logic          rd_en;
  logic          hit;
  logic          full;
  logic [SB-1:0] spare_new;
  logic          append;
  status_e       res_status;
  logic [SB-1:0] res_spare;

  assign search = (req_q == REQ_REMAP) || (req_q == REQ_VERIFY);
  assign more   = (cnt_q < used_q);
  assign rd_en  = cmd_i.scan && search && more;
  assign hit    = rd_vld_q && (rd_data_q[SB-1:0] == sec_q);

  assign sts_o.hit      = cmd_i.scan && search && hit;
  assign sts_o.scan_end = !search || (!rd_vld_q && !more);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign full = (CmpW'(used_q) >= CmpW'(spare_count_q)) || (used_q == UsedW'(TABLE_DEPTH));
  assign spare_new = spare_base_q + SB'(used_q);

  always_comb begin
    append     = 1'b0;
    res_status = ST_PONG;
    res_spare  = '0;
    case (req_q)
      REQ_REMAP: begin
        if (found_q) begin
          res_status = ST_ALREADY;
        end else if (full) begin
          res_status = ST_NO_SPARE;
        end else begin
          res_status = ST_REMAPPED;
          res_spare  = spare_new;
          append     = 1'b1;
        end
      end
      REQ_VERIFY: begin
        if (found_q) begin
          res_status = ST_FOUND;
          res_spare  = found_spare_q;
        end else begin
          res_status = ST_NOT_REMAPPED;
        end
      end
      REQ_CLEAR: begin
        res_status = ST_CLEARED;
      end
      default: begin
        res_status = ST_PONG;
      end
    endcase
  end

  always_comb begin
    used_d      = used_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.accept) begin
      cnt_d   = '0;
      found_d = 1'b0;
    end
    if (rd_en) begin
      cnt_d    = cnt_q + UsedW'(1);
      rd_vld_d = 1'b1;
    end
    if (sts_o.hit) begin
      found_d = 1'b1;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (append) begin
        used_d = used_q + UsedW'(1);
      end else if (req_q == REQ_CLEAR) begin
        used_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spare_base_q  <= '0;
      spare_count_q <= SPARE_COUNT_RESET;
      used_q        <= '0;
      cnt_q         <= '0;
      rd_vld_q      <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_SPARE_BASE) begin
          spare_base_q <= cfg_data_i;
        end else if (cfg_index_i == REG_SPARE_COUNT) begin
          spare_count_q <= cfg_data_i[SPARE_COUNT_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_req_i;
      sec_q <= in_sector_i;
    end
    if (sts_o.hit) begin
      found_spare_q <= rd_data_q[2*SB-1:SB];
    end
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_spare_q  <= res_spare;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && append) begin
      mem_q[used_q[AddrW-1:0]] <= {spare_new, sec_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[cnt_q[AddrW-1:0]];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_spare_o  = out_spare_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bsrt_checker.sv
// port-level checker of the bad sector remap table, with its bind
`default_nettype none
`include "assert_macros.svh"

module bsrt_checker
  import bsrt_pkg::*;
#(
  parameter int unsigned DATA_W = 48
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [2:0]        m_axis_tuser
);

  logic              out_stall;
  logic [DATA_W+2:0] out_beat;
  logic              spare_st;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_beat  = {m_axis_tuser, m_axis_tdata};
  assign spare_st  = (m_axis_tuser == ST_REMAPPED) || (m_axis_tuser == ST_FOUND);

  // a result beat waits unchanged until taken
  `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_beat), "stalled beat changed")

  // one request at a time: no beat accepted right after another
  `ASSERT_CLK(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "taken while busy")

  // spare is zero unless remapped or found
  `ASSERT_CLK(a_spare_zero, m_axis_tvalid && !spare_st |-> m_axis_tdata == '0, "stray nonzero spare")

  // nothing leaves the block while reset is held
  `ASSERT_CLK_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result beat during reset")

endmodule

bind bad_sector_remap_table bsrt_checker #(
  .DATA_W (DataW)
) u_bsrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/sv/bad_sector_remap_table_checker.sv
// checker for the bad sector remap table: table predictor and result scoreboard
`timescale 1ns / 1ps

module bad_sector_remap_table_checker
  import bsrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned SECTOR_BITS = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  input  logic [SECTOR_BITS-1:0] req_sector_i,
  input  logic [1:0]             req_type_i,
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  input  logic [SECTOR_BITS-1:0] res_spare_i,
  input  logic [2:0]             res_status_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SECTOR_BITS-1:0] cfg_data_i,
  output int                     errors_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     hits_o,
  output int                     full_o
);

  typedef struct packed {
    status_e                status;
    logic [SECTOR_BITS-1:0] spare;
  } remap_result_t;

  // predicted table contents, spare assigned at remap time kept per slot
  logic [SECTOR_BITS-1:0]   mapped_sector [TABLE_DEPTH];
  logic [SECTOR_BITS-1:0]   mapped_spare  [TABLE_DEPTH];
  int                       fill_count;
  logic [SECTOR_BITS-1:0]   base_reg;
  logic [SPARE_COUNT_W-1:0] count_reg;
  remap_result_t            expected_results [$];
  remap_result_t            oldest;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors_o++;
  endtask

  function automatic int lookup_slot(input logic [SECTOR_BITS-1:0] sector);
    for (int i = 0; i < fill_count; i++) begin
      if (mapped_sector[i] == sector) return i;
    end
    return -1;
  endfunction

  function automatic remap_result_t apply_request(input req_e op,
                                                  input logic [SECTOR_BITS-1:0] sector);
    remap_result_t res;
    int slot;
    int limit;
    res.status = ST_PONG;
    res.spare  = '0;
    limit = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
    slot  = lookup_slot(sector);
    case (op)
      REQ_REMAP: begin
        if (slot >= 0) begin
          res.status = ST_ALREADY;
        end else if (fill_count >= limit) begin
          res.status = ST_NO_SPARE;
        end else begin
          // spare address wraps at the sector width
          res.status = ST_REMAPPED;
          res.spare  = base_reg + SECTOR_BITS'(fill_count);
          mapped_sector[fill_count] = sector;
          mapped_spare[fill_count]  = res.spare;
          fill_count++;
        end
      end
      REQ_VERIFY: begin
        if (slot >= 0) begin
          res.status = ST_FOUND;
          res.spare  = mapped_spare[slot];
        end else begin
          res.status = ST_NOT_REMAPPED;
        end
      end
      REQ_CLEAR: begin
        fill_count = 0;
        res.status = ST_CLEARED;
      end
      default: res.status = ST_PONG;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count = 0;
      base_reg   = '0;
      count_reg  = SPARE_COUNT_RESET;
      expected_results.delete();
      errors_o   = 0;
      results_o  = 0;
      hits_o     = 0;
      full_o     = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SPARE_BASE:  base_reg = cfg_data_i;
          REG_SPARE_COUNT: count_reg = cfg_data_i[SPARE_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        results_o++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result status %0d spare 0x%h with no request waiting",
                                    res_status_i, res_spare_i));
        end else begin
          oldest = expected_results.pop_front();
          if (res_status_i !== oldest.status)
            report_mismatch($sformatf("status %0d, predicted %0d", res_status_i,
                                      oldest.status));
          if (res_spare_i !== oldest.spare)
            report_mismatch($sformatf("spare 0x%h, predicted 0x%h (status %0d)",
                                      res_spare_i, oldest.spare, oldest.status));
          if (oldest.status == ST_FOUND || oldest.status == ST_ALREADY) hits_o++;
          if (oldest.status == ST_NO_SPARE) full_o++;
        end
      end
      if (req_valid_i && req_ready_i)
        expected_results.push_back(apply_request(req_e'(req_type_i), req_sector_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: tb/sv/bad_sector_remap_table_tb.sv
// testbench top: stimulus, idle patterns and verdict for the bad sector remap table
`timescale 1ns / 1ps

module bad_sector_remap_table_tb;
  import bsrt_pkg::*;

  localparam int unsigned SectorW = 48;
  localparam int LongHold      = 300;   // receiver hold-off for the back-pressure test
  localparam int WatchdogLimit = 5000;  // cycles with no beat on any channel
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 160;
  localparam int FillItems     = 70;    // more remaps than the table has slots
  localparam int DrainCycles   = 80;    // a full 64-entry scan plus setup, with margin
  localparam logic [SectorW-1:0] AllOnes = '1;
  // index outside the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [SectorW-1:0]   s_tdata = '0;
  logic [1:0]           s_tuser = REQ_PING;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [SectorW-1:0]   m_tdata;
  logic [2:0]           m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SectorW-1:0]   cfg_data = '0;

  int errors;
  int pending;
  int results;
  int hits;
  int full;

  // idle and stall odds per cycle, in percent
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int req_sent [4] = '{default: 0};
  int cfg_writes = 0;
  logic [SectorW-1:0] known_sectors [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bad_sector_remap_table u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // sector
    .s_axis_tuser  (s_tuser),   // req_type
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // spare
    .m_axis_tuser  (m_tuser),   // status
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bad_sector_remap_table_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (s_tvalid),
    .req_ready_i  (s_tready),
    .req_sector_i (s_tdata),
    .req_type_i   (s_tuser),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_spare_i  (m_tdata),
    .res_status_i (m_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .errors_o     (errors),
    .pending_o    (pending),
    .results_o    (results),
    .hits_o       (hits),
    .full_o       (full)
  );

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: any beat on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               stall_cycles, pending);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [SectorW-1:0] random_sector();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[SectorW-1:0];
  endfunction

  // mostly sectors seen before so verify and repeated remap hit, some corners
  function automatic logic [SectorW-1:0] pick_sector();
    int roll;
    logic [SectorW-1:0] one_hot;
    roll = $urandom_range(99);
    one_hot = SectorW'(1) << $urandom_range(SectorW - 1);
    if (roll < 55 && known_sectors.size() > 0)
      return known_sectors[$urandom_range(known_sectors.size() - 1)];
    if (roll < 70) begin
      case ($urandom_range(3))
        0: return '0;
        1: return AllOnes;
        2: return one_hot;
        default: return ~one_hot;
      endcase
    end
    return random_sector();
  endfunction

  function automatic req_e pick_op();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return REQ_REMAP;
    if (roll < 85) return REQ_VERIFY;
    if (roll < 89) return REQ_CLEAR;
    return REQ_PING;
  endfunction

  // one request beat, with random idle cycles ahead of it
  task automatic send_req(input req_e op, input logic [SectorW-1:0] sector);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= sector;
    do @(posedge clk); while (!s_tready);
    req_sent[int'(op)]++;
    if (op == REQ_REMAP) begin
      known_sectors.push_back(sector);
      if (known_sectors.size() > 64) void'(known_sectors.pop_front());
    end
  endtask

  // sender pauses until every result is back, then lets the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SectorW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  initial begin
    logic [SectorW-1:0] junk;
    logic [SPARE_COUNT_W-1:0] count_sel;
    logic [SectorW-1:0] base_sel;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default config, empty table, hit and miss on both ends of the range
    send_req(REQ_PING, random_sector());
    send_req(REQ_VERIFY, '0);
    send_req(REQ_REMAP, '0);
    send_req(REQ_REMAP, AllOnes);
    send_req(REQ_REMAP, '0);
    send_req(REQ_VERIFY, AllOnes);
    send_req(REQ_VERIFY, '0);
    send_req(REQ_VERIFY, 48'h5555_5555_5555);
    send_req(REQ_CLEAR, AllOnes);
    send_req(REQ_VERIFY, '0);
    send_req(REQ_REMAP, 48'hAAAA_AAAA_AAAA);

    // spare base near the top so the second new slot wraps to zero; three spares,
    // upper data bits of the count write are junk and must be dropped
    drain();
    junk = random_sector();
    cfg_write(REG_SPARE_BASE, AllOnes - 48'd1);
    cfg_write(REG_SPARE_COUNT, {junk[SectorW-1:SPARE_COUNT_W], 7'd3});
    cfg_write(REG_UNMAPPED, random_sector());
    send_req(REQ_REMAP, 48'd1);
    send_req(REQ_REMAP, 48'd2);
    send_req(REQ_REMAP, 48'd3);
    send_req(REQ_VERIFY, 48'd1);

    // moving the spare base must not change what verify reports
    drain();
    cfg_write(REG_SPARE_BASE, 48'h0000_1234_5678);
    send_req(REQ_VERIFY, 48'd2);
    send_req(REQ_REMAP, 48'hAAAA_AAAA_AAAA);

    // no spares at all
    drain();
    cfg_write(REG_SPARE_COUNT, '0);
    send_req(REQ_CLEAR, '0);
    send_req(REQ_REMAP, 48'd5);
    send_req(REQ_VERIFY, 48'd5);

    // spare count above table depth: the table itself is the limit
    drain();
    cfg_write(REG_SPARE_BASE, 48'h8000_0000_0000);
    cfg_write(REG_SPARE_COUNT, 48'd127);
    send_req(REQ_CLEAR, random_sector());
    for (int i = 0; i < FillItems; i++) send_req(REQ_REMAP, random_sector());
    for (int i = 0; i < 5; i++) send_req(REQ_VERIFY, pick_sector());

    // random phases, idle pattern cycles through none, sender, receiver, both
    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      case (p % 4)
        0: base_sel = '0;
        1: base_sel = AllOnes;
        2: base_sel = random_sector();
        default: base_sel = AllOnes - 48'd40;
      endcase
      case (p)
        0: count_sel = 7'd64;
        1: count_sel = 7'd5;
        2: count_sel = 7'd127;
        3: count_sel = 7'd1;
        4: count_sel = 7'd0;
        5: count_sel = SPARE_COUNT_W'($urandom_range(127));
        6: count_sel = 7'd64;
        default: count_sel = 7'd16;
      endcase
      junk = random_sector();
      cfg_write(REG_SPARE_BASE, base_sel);
      cfg_write(REG_SPARE_COUNT, {junk[SectorW-1:SPARE_COUNT_W], count_sel});
      cfg_write(CFG_IDX_W'($urandom_range(2, 255)), random_sector());
      for (int i = 0; i < PhaseItems; i++) begin
        // long receiver hold-off while requests keep coming, so the input stalls
        if (p == 0 && i == 40) hold_req++;
        send_req(pick_op(), pick_sector());
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);

    $display("ran %0d remap, %0d verify, %0d clear, %0d ping requests with %0d register writes",
             req_sent[REQ_REMAP], req_sent[REQ_VERIFY], req_sent[REQ_CLEAR],
             req_sent[REQ_PING], cfg_writes);
    $display("%0d results compared: %0d table hits, %0d out of spares, %0d mismatches",
             results, hits, full, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bsrt_pkg.sv
hw/rtl/bsrt_ctrl.sv
hw/rtl/bsrt_dp.sv
hw/rtl/bad_sector_remap_table.sv
hw/rtl/bsrt_checker.sv
tb/sv/bad_sector_remap_table_checker.sv
tb/sv/bad_sector_remap_table_tb.sv
